@@ hw/rtl/pip_pkg.sv @@
package pip_pkg;

	localparam int MAX_POLYGONS = 8;
	localparam int MAX_VERTICES = 16;

	localparam int PID_W  = $clog2(MAX_POLYGONS);
	localparam int VID_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W = PID_W + VID_W;
	localparam int COORD_W = 16;
	localparam int OBST_W  = 3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

	// Tag traveling with each memory read
	typedef struct packed {
		logic is_edge;
		logic first_e;
		logic last_e;
		logic region;
	} edge_tag_t;

endpackage

@@ hw/rtl/pip_channels.sv @@
interface pip_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic [pip_pkg::PID_W-1:0]            polygon_id;
	logic [pip_pkg::VID_W-1:0]            vertex_index;
	logic                                 last_vertex;
	logic signed [pip_pkg::COORD_W-1:0]   coord_x;
	logic signed [pip_pkg::COORD_W-1:0]   coord_y;

	modport source(output valid, cmd, polygon_id, vertex_index, last_vertex, coord_x, coord_y,
		input ready);
	modport sink(input valid, cmd, polygon_id, vertex_index, last_vertex, coord_x, coord_y,
		output ready);
endinterface

interface pip_rsp_if;
	logic valid;
	logic ready;
	logic in_bounds;
	logic in_region;
	logic hits_obstacle;

	modport source(output valid, in_bounds, in_region, hits_obstacle, input ready);
	modport sink(input valid, in_bounds, in_region, hits_obstacle, output ready);
endinterface

interface pip_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pip_pkg::OBST_W-1:0]    data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ hw/rtl/point_in_region_with_obstacles.sv @@
// Polygon store with even-odd point containment. Load transactions (cmd 0) write one vertex.
// A query transaction (cmd 1) walks polygon 0 and then obstacles 1..obstacle_count,
// reading one vertex per cycle from the vertex memory: a polygon with n vertices takes n+1
// reads, the closing vertex first, and a polygon with no vertices takes none. The query
// then waits for the edge pipeline to drain; the drain stalls while an earlier result is
// still waiting. The result is held in an output register; new transactions are taken
// while it waits. The register obstacle_count is written through cfg with no wait states.
module point_in_region_with_obstacles (
	input  logic       clk,
	input  logic       arst_n,
	pip_req_if.sink    req,
	pip_rsp_if.source  rsp,
	pip_cfg_if.sink    cfg
);

	pip_pkg::state_t state_q, state_d;

	logic [pip_pkg::OBST_W-1:0] obst_q;
	logic [pip_pkg::CNT_W-1:0]  cnt_q [pip_pkg::MAX_POLYGONS];

	pip_pkg::vertex_t vmem [pip_pkg::MAX_POLYGONS * pip_pkg::MAX_VERTICES];

	logic signed [pip_pkg::COORD_W-1:0] px_q, py_q;
	logic [pip_pkg::PID_W-1:0] poly_q, poly_d, nobs_q, nobs_d;
	logic [pip_pkg::CNT_W-1:0] k_q, k_d;

	logic                      wr_en;
	logic [pip_pkg::ADDR_W-1:0] wr_addr;
	logic                      rd_en;
	logic [pip_pkg::ADDR_W-1:0] rd_addr;
	pip_pkg::edge_tag_t        rd_tag;
	logic [pip_pkg::CNT_W-1:0] cur_n;
	logic                      q_start, out_load;

	// stage 1: memory output
	logic               rd_v_s1;
	pip_pkg::edge_tag_t tag_s1;
	pip_pkg::vertex_t   rdata_s1;
	pip_pkg::vertex_t   prev_q;

	// stage 2: differences
	logic                             v_s2, straddle_s2;
	pip_pkg::edge_tag_t               tag_s2;
	logic signed [pip_pkg::COORD_W:0] dx_s2, d_s2, ex_s2, ey_s2;

	// stage 3: products
	logic                                   v_s3, straddle_s3, dpos_s3;
	pip_pkg::edge_tag_t                     tag_s3;
	logic signed [2*pip_pkg::COORD_W+1:0]   lhs_s3, rhs_s3;

	logic inside_q, region_q, hit_q;
	logic crossing, inside_nx, pipe_busy;

	logic rsp_valid_q, in_bounds_q, in_region_q, hits_obstacle_q;

	assign req.ready = (state_q == pip_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign pipe_busy = rd_v_s1 | v_s2 | v_s3;

	assign wr_en   = req.valid && req.ready && (req.cmd == pip_pkg::CMD_LOAD);
	assign wr_addr = {req.polygon_id, req.vertex_index};
	assign q_start = req.valid && req.ready && (req.cmd == pip_pkg::CMD_QUERY);
	assign cur_n   = cnt_q[poly_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		poly_d   = poly_q;
		k_d      = k_q;
		nobs_d   = nobs_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		rd_tag   = '0;
		out_load = 1'b0;
		unique case (state_q)
			pip_pkg::ST_IDLE: begin
				if (q_start) begin
					poly_d  = '0;
					k_d     = '0;
					nobs_d  = (obst_q > pip_pkg::OBST_W'(pip_pkg::MAX_POLYGONS - 1)) ?
						pip_pkg::PID_W'(pip_pkg::MAX_POLYGONS - 1) : pip_pkg::PID_W'(obst_q);
					state_d = pip_pkg::ST_ISSUE;
				end
			end
			pip_pkg::ST_ISSUE: begin
				if (cur_n != '0) begin
					rd_en = 1'b1;
					// first read fetches the closing vertex, then vertices in order
					rd_addr = {poly_q, (k_q == '0) ? pip_pkg::VID_W'(cur_n - 1'b1)
						: pip_pkg::VID_W'(k_q - 1'b1)};
					rd_tag.is_edge = (k_q != '0);
					rd_tag.first_e = (k_q == pip_pkg::CNT_W'(1));
					rd_tag.last_e  = (k_q == cur_n);
					rd_tag.region  = (poly_q == '0);
				end
				if (cur_n == '0 || k_q == cur_n) begin
					k_d = '0;
					if (poly_q == nobs_q) begin
						state_d = pip_pkg::ST_DRAIN;
					end else begin
						poly_d = poly_q + 1'b1;
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (!pipe_busy && (!rsp_valid_q || rsp.ready)) begin
					out_load = 1'b1;
					state_d  = pip_pkg::ST_IDLE;
				end
			end
			default: state_d = pip_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		poly_q <= poly_d;
		k_q    <= k_d;
		nobs_q <= nobs_d;
		if (q_start) begin
			px_q <= req.coord_x;
			py_q <= req.coord_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obst_q <= '0;
			for (int p = 0; p < pip_pkg::MAX_POLYGONS; p++) begin
				cnt_q[p] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				obst_q <= cfg.data;
			end
			if (wr_en && req.last_vertex) begin
				cnt_q[req.polygon_id] <= pip_pkg::CNT_W'(req.vertex_index) + 1'b1;
			end
		end
	end

	// vertex memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vmem[wr_addr] <= '{x: req.coord_x, y: req.coord_y};
		end
		rdata_s1 <= vmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			v_s2    <= rd_v_s1 && tag_s1.is_edge;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= rd_tag;
		if (rd_v_s1) begin
			prev_q <= rdata_s1;
		end
		// i is the vertex just read, j the one before it
		tag_s2      <= tag_s1;
		dx_s2       <= 17'(px_q) - 17'(rdata_s1.x);
		d_s2        <= 17'(prev_q.y) - 17'(rdata_s1.y);
		ex_s2       <= 17'(prev_q.x) - 17'(rdata_s1.x);
		ey_s2       <= 17'(py_q) - 17'(rdata_s1.y);
		straddle_s2 <= (rdata_s1.y > py_q) != (prev_q.y > py_q);

		tag_s3      <= tag_s2;
		lhs_s3      <= dx_s2 * d_s2;
		rhs_s3      <= ex_s2 * ey_s2;
		dpos_s3     <= (d_s2 > 0);
		straddle_s3 <= straddle_s2;
	end

	assign crossing  = straddle_s3 && (dpos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3));
	assign inside_nx = (tag_s3.first_e ? 1'b0 : inside_q) ^ crossing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			region_q <= 1'b0;
			hit_q    <= 1'b0;
		end else if (q_start) begin
			region_q <= 1'b0;
			hit_q    <= 1'b0;
		end else if (v_s3) begin
			inside_q <= inside_nx;
			if (tag_s3.last_e) begin
				if (tag_s3.region) begin
					region_q <= inside_nx;
				end else begin
					hit_q <= hit_q | inside_nx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			in_bounds_q     <= region_q & ~hit_q;
			in_region_q     <= region_q;
			hits_obstacle_q <= hit_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.in_bounds     = in_bounds_q;
	assign rsp.in_region     = in_region_q;
	assign rsp.hits_obstacle = hits_obstacle_q;

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == pip_pkg::ST_DRAIN))
		else $error("result raised outside drain");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pip_pkg::ST_IDLE |-> !pipe_busy)
		else $error("edge pipeline busy while idle");

	a_no_write_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !pipe_busy && !rd_en)
		else $error("vertex write overlaps a query walk");

	a_hit_needs_obstacle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_DRAIN && hit_q) |-> nobs_q != '0)
		else $error("obstacle hit with no active obstacle");

endmodule
